[src/assert_macros.svh]
// Assertion macros shared by the brake mapper RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DFBM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DFBM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dfbm_pkg.sv]
// Types and constants shared by the distance frame brake mapper.
// No dependencies.
`timescale 1ns / 1ps

package dfbm_pkg;

  typedef enum logic [1:0] {
    OUT_EVAL   = 2'd0,
    OUT_CRC    = 2'd1,
    OUT_STATUS = 2'd2
  } outcome_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] dist_mm;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CRC,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_REM,
    B_DIV,
    B_MUL,
    B_SCALE
  } back_state_t;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd300;
  localparam logic [15:0] MIN_DIST_RST  = 16'd50;
  localparam logic [31:0] PERIOD_RST    = 32'd1000000;

endpackage

[src/dfbm_front.sv]
// Front end: accepts frames, filters them and checks the CRC-8 one byte a cycle.
// Depends on dfbm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfbm_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_extended_id,
  input  logic [28:0]             in_frame_id,
  input  logic [3:0]              in_data_length,
  input  logic [7:0]              in_data0,
  input  logic [7:0]              in_data1,
  input  logic [7:0]              in_data2,
  input  logic [7:0]              in_data3,
  input  logic [7:0]              in_data4,
  input  logic [7:0]              in_data5,
  input  logic [7:0]              in_data6,
  input  logic [7:0]              in_data7,
  output logic                    push,
  output dfbm_pkg::entry_t        push_data,
  input  dfbm_pkg::q_stat_t       q_stat
);
  import dfbm_pkg::*;

  localparam logic [7:0]  CRC_POLY  = 8'h07;
  localparam logic [10:0] ID_MATCH  = 11'h100;
  localparam logic [3:0]  DLC_FULL  = 4'd8;
  localparam logic [2:0]  LAST_BYTE = 3'd6;

  front_state_t fs_r, fs_nxt;
  logic [55:0]  shift_r;
  logic [7:0]   crc_r;
  logic [7:0]   crc_rx_r;
  logic [7:0]   status_r;
  logic [15:0]  dist_r;
  logic [2:0]   cnt_r;
  logic         accept;
  logic         frame_ok;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  assign accept   = start && !busy;
  assign frame_ok = !in_extended_id && (in_data_length == DLC_FULL) &&
                    (in_frame_id[10:0] == ID_MATCH);

  always_comb begin
    fs_nxt = fs_r;
    unique case (fs_r)
      F_IDLE: begin
        if (start && frame_ok) begin
          fs_nxt = F_CRC;
        end
      end
      F_CRC: begin
        if (cnt_r == LAST_BYTE) begin
          fs_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          fs_nxt = F_IDLE;
        end
      end
      default: fs_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    push = 1'b0;
    unique case (fs_r)
      F_IDLE:  busy = 1'b0;
      F_CRC:   busy = 1'b1;
      F_PUSH:  push = !q_stat.full;
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    push_data.dist_mm = dist_r;
    if (crc_r != crc_rx_r) begin
      push_data.outcome = OUT_CRC;
    end else if (status_r != 8'd0) begin
      push_data.outcome = OUT_STATUS;
    end else begin
      push_data.outcome = OUT_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= F_IDLE;
    end else begin
      fs_r <= fs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_ok) begin
      shift_r  <= {in_data0, in_data1, in_data2, in_data3, in_data4, in_data5, in_data6};
      crc_r    <= 8'd0;
      crc_rx_r <= in_data7;
      status_r <= in_data3;
      dist_r   <= {in_data0, in_data1};
      cnt_r    <= 3'd0;
    end else if (fs_r == F_CRC) begin
      crc_r   <= crc_step(crc_r, shift_r[55:48]);
      shift_r <= shift_r << 8;
      cnt_r   <= cnt_r + 3'd1;
    end
  end

  `DFBM_ASSERT_NXT(a_front_crc_run, (fs_r == F_CRC) && (cnt_r != LAST_BYTE), fs_r == F_CRC, "CRC pass left early")

endmodule

[src/dfbm_fifo.sv]
// Two-entry queue between the front end and the back end.
// Depends on dfbm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfbm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dfbm_pkg::entry_t   push_data,
  input  logic               pop,
  output dfbm_pkg::entry_t   pop_data,
  output dfbm_pkg::q_stat_t  q_stat
);
  import dfbm_pkg::*;

  entry_t         mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW:0]   count_r;

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (QPW + 1)'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `DFBM_ASSERT_IMP(a_fifo_no_overflow, push, !q_stat.full || pop, "push into a full queue")
  `DFBM_ASSERT_IMP(a_fifo_no_underflow, pop, !q_stat.empty, "pop from an empty queue")

endmodule

[src/dfbm_back.sv]
// Back end: configuration registers, distance mapping, percent division and duty scaling.
// Depends on dfbm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfbm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           pop,
  input  dfbm_pkg::entry_t               pop_data,
  input  dfbm_pkg::q_stat_t              q_stat,
  output logic                           out_valid,
  output logic                           out_brake_on,
  output logic [6:0]                     out_brake_pct,
  output logic [31:0]                    out_duty_ns,
  output logic [1:0]                     out_outcome
);
  import dfbm_pkg::*;

  localparam logic [6:0]  FULL_PERCENT = 7'd100;
  localparam logic [60:0] RECIP_100    = 61'd1374389535;
  localparam logic [26:0] RECIP_SMALL  = 27'd5243;
  localparam logic [2:0]  DIV_STEPS    = 3'd6;

  back_state_t bs_r, bs_nxt;
  logic [15:0] threshold_r;
  logic [15:0] min_dist_r;
  logic [31:0] period_r;
  entry_t      ent_r;
  logic [25:0] q_r;
  logic [6:0]  r_r;
  logic [6:0]  pct_r;
  logic        div_en_r;
  logic [23:0] rem_r;
  logic [23:0] dvs_r;
  logic [2:0]  cnt_r;
  logic [31:0] qp_r;
  logic [13:0] rp_r;
  logic        out_valid_r;
  logic [6:0]  out_pct_r;
  logic [31:0] out_duty_r;
  outcome_t    out_outcome_r;

  logic [60:0] recip_prod;
  logic [15:0] span;
  logic [15:0] diff;
  logic [23:0] num;
  logic [31:0] q_times_100;
  logic        ge;
  logic [6:0]  pct_clamp;
  logic [32:0] qp_full;
  logic [13:0] rp_full;
  logic [26:0] small_prod;

  assign cfg_ready = 1'b1;

  assign recip_prod  = {31'b0, period_r[31:2]} * RECIP_100;
  assign span        = threshold_r - min_dist_r;
  assign diff        = threshold_r - ent_r.dist_mm;
  assign num         = {1'b0, diff, 7'b0} + {2'b0, diff, 6'b0} + {5'b0, diff, 3'b0} +
                       {8'b0, span};
  assign q_times_100 = {q_r, 6'b0} + {1'b0, q_r, 5'b0} + {4'b0, q_r, 2'b0};
  assign ge          = (rem_r >= dvs_r);
  assign pct_clamp   = (pct_r > FULL_PERCENT) ? FULL_PERCENT : pct_r;
  assign qp_full     = {7'b0, q_r} * {26'b0, pct_clamp};
  assign rp_full     = {7'b0, r_r} * {7'b0, pct_clamp};
  assign small_prod  = {13'b0, rp_r} * RECIP_SMALL;

  always_comb begin
    bs_nxt = bs_r;
    unique case (bs_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          bs_nxt = B_PREP;
        end
      end
      B_PREP:  bs_nxt = B_REM;
      B_REM:   bs_nxt = div_en_r ? B_DIV : B_MUL;
      B_DIV: begin
        if (cnt_r == 3'd0) begin
          bs_nxt = B_MUL;
        end
      end
      B_MUL:   bs_nxt = B_SCALE;
      B_SCALE: bs_nxt = B_IDLE;
      default: bs_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (bs_r)
      B_IDLE:  pop = !q_stat.empty;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= B_IDLE;
      out_valid_r <= 1'b0;
      threshold_r <= THRESHOLD_RST;
      min_dist_r  <= MIN_DIST_RST;
      period_r    <= PERIOD_RST;
    end else begin
      bs_r        <= bs_nxt;
      out_valid_r <= (bs_r == B_SCALE);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_THRESHOLD: threshold_r <= cfg_data[15:0];
          CFG_MIN_DIST:  min_dist_r  <= cfg_data[15:0];
          CFG_PERIOD:    period_r    <= cfg_data;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (bs_r)
      B_IDLE: begin
        ent_r <= pop_data;
      end
      B_PREP: begin
        q_r      <= recip_prod[60:35];
        pct_r    <= 7'd0;
        div_en_r <= 1'b0;
        rem_r    <= num;
        dvs_r    <= {1'b0, span, 7'b0};
        if (ent_r.outcome != OUT_EVAL || ent_r.dist_mm >= threshold_r) begin
          pct_r <= 7'd0;
        end else if (ent_r.dist_mm <= min_dist_r) begin
          pct_r <= FULL_PERCENT;
        end else begin
          div_en_r <= 1'b1;
        end
      end
      B_REM: begin
        r_r   <= 7'(period_r - q_times_100);
        cnt_r <= DIV_STEPS;
      end
      B_DIV: begin
        if (ge) begin
          rem_r <= rem_r - dvs_r;
        end
        pct_r <= {pct_r[5:0], ge};
        dvs_r <= dvs_r >> 1;
        cnt_r <= cnt_r - 3'd1;
      end
      B_MUL: begin
        pct_r <= pct_clamp;
        qp_r  <= qp_full[31:0];
        rp_r  <= rp_full;
      end
      B_SCALE: begin
        out_pct_r     <= pct_r;
        out_duty_r    <= qp_r + {24'b0, small_prod[26:19]};
        out_outcome_r <= ent_r.outcome;
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_brake_pct = out_pct_r;
  assign out_brake_on  = (out_pct_r != 7'd0);
  assign out_duty_ns   = out_duty_r;
  assign out_outcome   = out_outcome_r;

  `DFBM_ASSERT_NXT(a_back_single_strobe, out_valid_r, !out_valid_r, "result strobe held longer than one cycle")
  `DFBM_ASSERT_IMP(a_back_reject_zero, out_valid_r && (out_outcome_r != OUT_EVAL), (out_pct_r == 7'd0) && (out_duty_r == 32'd0), "rejected frame carries a brake value")
  `DFBM_ASSERT_IMP(a_back_pct_range, out_valid_r, out_pct_r <= FULL_PERCENT, "brake percent above full scale")

endmodule

[src/distance_frame_brake_mapper_core.sv]
// Top level of the distance frame brake mapper: front end, queue and back end.
// Depends on dfbm_pkg, dfbm_front, dfbm_fifo and dfbm_back.
//
//   Channel  Handshake                 Beat content
//   -------  ------------------------  -----------------------------------------
//   input    start & !busy             in_extended_id, in_frame_id, in_data_length,
//                                      in_data0 .. in_data7
//   result   out_valid (one cycle)     out_brake_on, out_brake_pct,
//                                      out_duty_ns, out_outcome
//   config   cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A frame holds the front end for one beat, seven CRC byte steps and one queue push, so busy
// stays high from each accepted beat until its push is taken; dropped frames leave busy low.
// The back end pops an entry, prepares it, forms the remainder, runs the percent division only
// for a frame that needs it, then multiplies and scales; it takes no new entry until idle again.
// Reset is synchronous and active low; cfg_ready is always high.
// The receiver cannot stall; only a full two-entry queue holds busy high longer.
`timescale 1ns / 1ps

module distance_frame_brake_mapper_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_extended_id,
  input  logic [28:0]                    in_frame_id,
  input  logic [3:0]                     in_data_length,
  input  logic [7:0]                     in_data0,
  input  logic [7:0]                     in_data1,
  input  logic [7:0]                     in_data2,
  input  logic [7:0]                     in_data3,
  input  logic [7:0]                     in_data4,
  input  logic [7:0]                     in_data5,
  input  logic [7:0]                     in_data6,
  input  logic [7:0]                     in_data7,
  output logic                           out_valid,
  output logic                           out_brake_on,
  output logic [6:0]                     out_brake_pct,
  output logic [31:0]                    out_duty_ns,
  output logic [1:0]                     out_outcome,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import dfbm_pkg::*;

  logic    push;
  entry_t  push_data;
  logic    pop;
  entry_t  pop_data;
  q_stat_t q_stat;

  dfbm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_extended_id (in_extended_id),
    .in_frame_id    (in_frame_id),
    .in_data_length (in_data_length),
    .in_data0       (in_data0),
    .in_data1       (in_data1),
    .in_data2       (in_data2),
    .in_data3       (in_data3),
    .in_data4       (in_data4),
    .in_data5       (in_data5),
    .in_data6       (in_data6),
    .in_data7       (in_data7),
    .push           (push),
    .push_data      (push_data),
    .q_stat         (q_stat)
  );

  dfbm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  dfbm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pop           (pop),
    .pop_data      (pop_data),
    .q_stat        (q_stat),
    .out_valid     (out_valid),
    .out_brake_on  (out_brake_on),
    .out_brake_pct (out_brake_pct),
    .out_duty_ns   (out_duty_ns),
    .out_outcome   (out_outcome)
  );

endmodule
